>>> hw/rtl/vrdc_pkg.sv
// Shared types, constants and the seven-segment decoder for the decade counter.
package vrdc_pkg;

  localparam int unsigned StickW = 10;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SegW   = 7;
  localparam int unsigned SpeedW = 2;
  localparam int unsigned PreW   = 3;

  localparam logic [StickW-1:0] UpperRst = 10'd800;
  localparam logic [StickW-1:0] LowerRst = 10'd200;

  localparam logic [SpeedW-1:0] SpeedMin = 2'd1;
  localparam logic [SpeedW-1:0] SpeedMid = 2'd2;
  localparam logic [SpeedW-1:0] SpeedMax = 2'd3;

  localparam logic [DigitW-1:0] DigitLast = 4'd9;

  // configuration register indexes
  typedef enum logic {
    CfgUpper = 1'b0,
    CfgLower = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhRun      = 3'd1,
    PhRunRel   = 3'd2,
    PhPause    = 3'd3,
    PhPauseRel = 3'd4
  } phase_e;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [SegW-1:0]   segments;
    logic              running;
  } result_t;

  // bit0 = segment a ... bit6 = segment g
  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/vrdc_if.sv
// Request channel interfaces for tick requests and display results.
interface vrdc_in_if;
  logic       valid;
  logic       ready;
  logic       button_level;
  logic [9:0] stick_sample;

  modport source (output valid, button_level, stick_sample, input ready);
  modport sink   (input valid, button_level, stick_sample, output ready);
endinterface

interface vrdc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic [6:0] segments;
  logic       running;

  modport source (output valid, digit, segments, running, input ready);
  modport sink   (input valid, digit, segments, running, output ready);
endinterface

>>> hw/rtl/vrdc_core.sv
// Speed level, start/pause machine, prescaler and digit state with per-tick update.
module vrdc_core import vrdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              button_level_i,
  input  logic [StickW-1:0] stick_sample_i,
  input  logic [StickW-1:0] upper_i,
  input  logic [StickW-1:0] lower_i,
  output result_t           result_o
);

  phase_e            phase_q, phase_d;
  logic [SpeedW-1:0] speed_q, speed_d;
  logic [PreW-1:0]   pre_q, pre_d;
  logic [DigitW-1:0] digit_q, digit_d;

  logic [PreW-1:0]   pre_inc;
  logic [PreW-1:0]   period;
  logic              run;
  logic [DigitW-1:0] digit_adv;

  // speed nudge: upper band wins
  always_comb begin
    speed_d = speed_q;
    if (stick_sample_i > upper_i) begin
      if (speed_q < SpeedMax) speed_d = speed_q + SpeedW'(1);
    end else if (stick_sample_i < lower_i) begin
      if (speed_q > SpeedMin) speed_d = speed_q - SpeedW'(1);
    end
  end

  // phase machine
  always_comb begin
    unique case (phase_q)
      PhRun:      phase_d = button_level_i ? PhRunRel   : PhRun;
      PhRunRel:   phase_d = button_level_i ? PhRunRel   : PhPause;
      PhPause:    phase_d = button_level_i ? PhPauseRel : PhPause;
      PhPauseRel: phase_d = button_level_i ? PhPauseRel : PhRun;
      default:    phase_d = button_level_i ? PhIdle     : PhRun;
    endcase
  end

  always_comb begin
    run = (phase_d == PhRun) || (phase_d == PhRunRel);
  end

  // prescaler period judged against the new speed
  always_comb begin
    case (speed_d)
      SpeedMax: period = PreW'(1);
      SpeedMid: period = PreW'(2);
      default:  period = PreW'(4);
    endcase
    pre_inc   = pre_q + PreW'(1);
    digit_adv = (digit_q >= DigitLast) ? '0 : digit_q + DigitW'(1);
    pre_d     = pre_q;
    digit_d   = (digit_q > DigitLast) ? '0 : digit_q;
    if (run) begin
      if (pre_inc >= period) begin
        pre_d   = '0;
        digit_d = digit_adv;
      end else begin
        pre_d   = pre_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      speed_q <= SpeedMid;
      pre_q   <= '0;
      digit_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      speed_q <= speed_d;
      pre_q   <= pre_d;
      digit_q <= digit_d;
    end
  end

  always_comb begin
    result_o.digit    = digit_d;
    result_o.segments = seg_decode(digit_d);
    result_o.running  = run;
  end

endmodule

>>> hw/rtl/variable_rate_decade_counter_7seg_top.sv
// Top level of the variable-rate decade counter with seven-segment output.
//
// Usage
//   in_if  : one request per timer tick, carrying the raw button level
//            (0 = pressed) and a 10-bit joystick sample.
//   out_if : one result request per tick: digit, seven-segment pattern,
//            running flag.
//   cfg_*  : write port for the two stick thresholds; index 0 upper,
//            index 1 lower. Write only while no tick is in flight.
// Timing
//   A tick lands in the input register, then moves into the state and the
//   result register when out_if can take it; its result is then valid on out_if.
//   One tick per cycle is sustained while out_if.ready stays high; the state
//   update sits between the input register and the result register.
// Reset
//   Phase idle, speed level 2, prescaler and digit 0, thresholds 800/200.
// Backpressure
//   While out_if.ready is low a valid result register holds; the input
//   register may still fill, so one more tick is taken before in_if.ready
//   drops.
module variable_rate_decade_counter_7seg_top import vrdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  vrdc_in_if.sink           in_if,
  vrdc_out_if.source        out_if,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [StickW-1:0] cfg_wdata_i
);

  logic [StickW-1:0] upper_q, lower_q;

  // input register
  logic              in_vld_q;
  logic              btn_q;
  logic [StickW-1:0] stick_q;

  // result register
  logic    out_vld_q;
  result_t res_q;
  result_t res_d;

  logic step;     // input register moves into the state/result
  logic in_take;  // new request accepted

  always_comb begin
    step    = in_vld_q && (!out_vld_q || out_if.ready);
    in_take = in_if.valid && in_if.ready;
  end

  assign in_if.ready = !in_vld_q || step;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UpperRst;
      lower_q <= LowerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgUpper: upper_q <= cfg_wdata_i;
        CfgLower: lower_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      btn_q   <= in_if.button_level;
      stick_q <= in_if.stick_sample;
    end
  end

  vrdc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .button_level_i (btn_q),
    .stick_sample_i (stick_q),
    .upper_i        (upper_q),
    .lower_i        (lower_q),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid    = out_vld_q;
  assign out_if.digit    = res_q.digit;
  assign out_if.segments = res_q.segments;
  assign out_if.running  = res_q.running;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the variable-rate decade counter with seven-segment output.
module testbench;
  import vrdc_pkg::*;

  // Run length guard on the whole simulation.
  localparam int unsigned CycleLimit = 200000;
  // Slack after the last owed result has come back.
  localparam int unsigned DrainCycles = 8;

  // Own segment table: bit0 = a ... bit6 = g.
  localparam logic [SegW-1:0] DigitSegs [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx_i;
  logic [StickW-1:0] cfg_wdata_i;

  vrdc_in_if  tick_if ();
  vrdc_out_if disp_if ();

  variable_rate_decade_counter_7seg_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (tick_if),
    .out_if      (disp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the counter state and the two thresholds.
  logic [StickW-1:0] upper_thr;
  logic [StickW-1:0] lower_thr;
  phase_e            toggle_phase;
  logic [SpeedW-1:0] speed;
  logic [PreW-1:0]   prescale;
  logic [DigitW-1:0] digit_now;

  // Display results still owed by the block, oldest first.
  result_t display_q [$];

  int unsigned cycle_count;
  int unsigned fault_count;
  // Random idling on both sides; off for the quiet stretch.
  bit          gaps_on;
  // Receiver hold-off, counted down by the receiver process itself.
  int          hold_left;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor: one tick in, one display result out. The speed update comes
  // first, then the start/pause machine, then the prescaler and the digit.
  // ---------------------------------------------------------------------
  function automatic result_t predict_display(input logic btn, input logic [StickW-1:0] stick);
    result_t           res;
    logic              counting;
    logic [PreW-1:0]   period;

    // upper test wins when the stick sits in both bands
    if (stick > upper_thr) begin
      if (speed < SpeedMax) speed = speed + 1'b1;
    end else if (stick < lower_thr) begin
      if (speed > SpeedMin) speed = speed - 1'b1;
    end

    // button level 0 means pressed
    case (toggle_phase)
      PhRun:      toggle_phase = btn ? PhRunRel : PhRun;
      PhRunRel:   toggle_phase = btn ? PhRunRel : PhPause;
      PhPause:    toggle_phase = btn ? PhPauseRel : PhPause;
      PhPauseRel: toggle_phase = btn ? PhPauseRel : PhRun;
      default:    toggle_phase = btn ? PhIdle : PhRun;
    endcase
    counting = (toggle_phase == PhRun) || (toggle_phase == PhRunRel);

    if (counting) begin
      // period judged against the speed after this tick's nudge
      period   = (speed == SpeedMax) ? 3'd1 : (speed == SpeedMid) ? 3'd2 : 3'd4;
      prescale = prescale + 1'b1;
      if (prescale >= period) begin
        prescale  = '0;
        digit_now = (digit_now == DigitLast) ? '0 : digit_now + 1'b1;
      end
    end

    res.digit    = digit_now;
    res.segments = DigitSegs[digit_now];
    res.running  = counting;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: receiver ready with random stalls and a counted hold-off,
  // plus the checker on every accepted result request.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      disp_if.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      disp_if.ready <= !(gaps_on && ($urandom_range(0, 99) < 22));
    end
  end

  always @(posedge clk_i) begin : check_display
    result_t want;
    if (rst_ni && disp_if.valid && disp_if.ready) begin
      if (display_q.size() == 0) begin
        $error("unexpected result: digit %0d segments %0h running %0b",
               disp_if.digit, disp_if.segments, disp_if.running);
        fault_count++;
      end else begin
        want = display_q.pop_front();
        if (disp_if.digit !== want.digit) begin
          $error("digit: expected %0d, actual %0d", want.digit, disp_if.digit);
          fault_count++;
        end
        if (disp_if.segments !== want.segments) begin
          $error("segments: expected %0h, actual %0h", want.segments, disp_if.segments);
          fault_count++;
        end
        if (disp_if.running !== want.running) begin
          $error("running: expected %0b, actual %0b", want.running, disp_if.running);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side helpers.
  // ---------------------------------------------------------------------

  // Offer one tick request; valid stays high after accept so back-to-back
  // requests never lower and raise it in the same step.
  task automatic send_tick(input logic btn, input logic [StickW-1:0] stick);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 22) begin
        tick_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    tick_if.valid        <= 1'b1;
    tick_if.button_level <= btn;
    tick_if.stick_sample <= stick;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    display_q.push_back(predict_display(btn, stick));
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_display;
    tick_if.valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Threshold write; only called with the block drained.
  task automatic write_threshold(input cfg_idx_e idx, input logic [StickW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == CfgUpper) upper_thr = value;
    else                 lower_thr = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [StickW-1:0] up, input logic [StickW-1:0] low);
    write_threshold(CfgUpper, up);
    write_threshold(CfgLower, low);
  endtask

  // Mostly sticks between the thresholds, some across, some on the edges.
  function automatic logic [StickW-1:0] pick_stick;
    logic [StickW-1:0] s;
    case ($urandom_range(0, 3))
      0: s = StickW'($urandom_range(0, 1023));
      1, 2: begin
        if (lower_thr <= upper_thr) s = StickW'($urandom_range(upper_thr, lower_thr));
        else                        s = StickW'($urandom_range(0, 1023));
      end
      default: begin
        case ($urandom_range(0, 5))
          0: s = '0;
          1: s = '1;
          2: s = upper_thr;
          3: s = upper_thr + 1'b1;
          4: s = lower_thr;
          default: s = lower_thr - 1'b1;
        endcase
      end
    endcase
    return s;
  endfunction

  // Button held in runs of random length so the start/pause machine walks
  // all its phases; noise_pct of the ticks get a random level instead.
  task automatic random_ticks(input int unsigned count, input int unsigned noise_pct);
    logic        level;
    logic        btn;
    int unsigned run_left;
    level    = 1'b1;
    run_left = 0;
    repeat (count) begin
      if (run_left == 0) begin
        level    = ~level;
        run_left = $urandom_range(1, 8);
      end
      run_left--;
      btn = ($urandom_range(0, 99) < noise_pct) ? 1'($urandom_range(0, 1)) : level;
      send_tick(btn, pick_stick());
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Button released from reset: stays idle, digit 0, not running.
  task automatic test_idle_after_reset;
    send_tick(1'b1, 10'd512);
    send_tick(1'b1, 10'd300);
    send_tick(1'b1, 10'd700);
  endtask

  // Start, hold, release, pause, release, resume at the default speed.
  task automatic test_start_pause_toggle;
    send_tick(1'b0, 10'd500);
    send_tick(1'b0, 10'd500);
    send_tick(1'b1, 10'd500);
    send_tick(1'b1, 10'd500);
    send_tick(1'b0, 10'd500);
    send_tick(1'b1, 10'd500);
    send_tick(1'b0, 10'd500);
    send_tick(1'b1, 10'd500);
  endtask

  // Stick at both ends and on each threshold while running; speed clamps.
  task automatic test_speed_levels;
    send_tick(1'b1, 10'd1023);
    send_tick(1'b1, 10'd1023);
    send_tick(1'b1, 10'd801);
    send_tick(1'b1, 10'd800);
    send_tick(1'b1, 10'd0);
    send_tick(1'b1, 10'd0);
    send_tick(1'b1, 10'd0);
    send_tick(1'b1, 10'd199);
    send_tick(1'b1, 10'd200);
    send_tick(1'b1, 10'd1023);
    drain_display();
  endtask

  // Extreme and crossed thresholds; with upper below lower the upper test
  // still wins for sticks in both bands.
  task automatic test_threshold_extremes;
    set_thresholds(10'd0, 10'd1023);
    send_tick(1'b1, 10'd0);
    send_tick(1'b1, 10'd1);
    send_tick(1'b1, 10'd0);
    send_tick(1'b1, 10'd0);
    drain_display();
    set_thresholds(10'd1023, 10'd0);
    send_tick(1'b1, 10'd1023);
    send_tick(1'b1, 10'd0);
    drain_display();
  endtask

  // Default thresholds; the first stretch runs with no idling at all.
  task automatic test_random_default;
    set_thresholds(UpperRst, LowerRst);
    gaps_on = 1'b0;
    random_ticks(100, 5);
    drain_display();
    gaps_on = 1'b1;
    random_ticks(150, 5);
    drain_display();
  endtask

  // Several random threshold settings, then the corners.
  task automatic test_random_thresholds;
    logic [StickW-1:0] corner_up [4];
    logic [StickW-1:0] corner_low [4];
    corner_up  = '{10'd1023, 10'd0, 10'd0, 10'd1023};
    corner_low = '{10'd0, 10'd1023, 10'd0, 10'd1023};
    repeat (4) begin
      set_thresholds(StickW'($urandom_range(500, 1023)), StickW'($urandom_range(0, 500)));
      random_ticks(50, 5);
      drain_display();
    end
    for (int i = 0; i < 4; i++) begin
      set_thresholds(corner_up[i], corner_low[i]);
      random_ticks(40, 5);
      drain_display();
    end
  endtask

  // Receiver holds off while requests keep coming: input must stall.
  task automatic test_backpressure;
    set_thresholds(UpperRst, LowerRst);
    gaps_on   = 1'b0;
    hold_left = 70;
    random_ticks(40, 0);
    gaps_on = 1'b1;
    random_ticks(20, 10);
    drain_display();
  endtask

  // Sender pauses with the block drained mid-sequence, then carries on
  // with noisy button levels.
  task automatic test_sender_pause;
    random_ticks(50, 5);
    drain_display();
    random_ticks(150, 50);
    drain_display();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CfgUpper;
    cfg_wdata_i          = '0;
    tick_if.valid        = 1'b0;
    tick_if.button_level = 1'b1;
    tick_if.stick_sample = '0;
    disp_if.ready        = 1'b0;
    cycle_count          = 0;
    fault_count          = 0;
    gaps_on              = 1'b1;
    hold_left            = 0;

    // shadow state matches the block's reset
    upper_thr    = UpperRst;
    lower_thr    = LowerRst;
    toggle_phase = PhIdle;
    speed        = SpeedMid;
    prescale     = '0;
    digit_now    = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_start_pause_toggle();
    test_speed_levels();
    test_threshold_extremes();
    test_random_default();
    test_random_thresholds();
    test_backpressure();
    test_sender_pause();

    drain_display();
    if (display_q.size() != 0) begin
      $error("%0d expected results never arrived", display_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
